@@ rtl/ses_pkg.sv @@
package ses_pkg;

    localparam int E_W     = 18;
    localparam int RAY_W   = 20;
    localparam int ROW_W   = 54;
    localparam int PROD_W  = 38;
    localparam int LINE_W  = 40;
    localparam int HALF_W  = 20;
    localparam int PPL_W   = 41;
    localparam int PPH_W   = 40;
    localparam int RND_W   = 30;
    localparam int SQ_W    = 60;
    localparam int DEN_W   = 62;
    localparam int NUM_W   = 61;
    localparam int NMAG_W  = 60;
    localparam int FOC_W   = 16;
    localparam int FPL_W   = 48;
    localparam int FPH_W   = 44;
    localparam int FP_W    = 76;
    localparam int S_W     = 5;
    localparam int SH_W    = FP_W + 31;
    localparam int NUMER_W = 78;
    localparam int Q_W     = 31;
    localparam int DIST_W  = 16;
    localparam int REM_W   = Q_W + DIST_W;
    localparam int APB_AW  = 6;
    localparam int APB_DW  = 64;

    localparam logic [DEN_W-1:0]  DEN_FLOOR   = 62'd282;
    localparam logic [DIST_W-1:0] DIST_MAX    = 16'hFFFF;
    localparam logic [FOC_W-1:0]  FOCAL_RESET = 16'd16000;
    localparam logic [FOC_W-1:0]  THR_RESET   = 16'd32;

    typedef logic signed [RAY_W-1:0] ray_t;

    typedef struct packed {
        ray_t src_x;
        ray_t src_y;
        ray_t src_z;
        ray_t dst_x;
        ray_t dst_y;
        ray_t dst_z;
    } corr_t;

    typedef struct packed {
        logic [ROW_W-1:0] row0;
        logic [ROW_W-1:0] row1;
        logic [ROW_W-1:0] row2;
        logic [FOC_W-1:0] focal;
        logic [FOC_W-1:0] thr;
    } cfg_t;

    typedef struct packed {
        logic [NUMER_W-1:0] numer;
        logic               degen;
    } side_t;

    // |x| rounded half up from 2^-32 to 2^-24
    function automatic logic [RND_W-1:0] round_mag(input logic signed [LINE_W-1:0] x);
        logic [LINE_W-1:0] m;
        logic [LINE_W-1:0] r;
        m = x[LINE_W-1] ? LINE_W'(-x) : LINE_W'(x);
        r = m + LINE_W'(128);
        return r[8 +: RND_W];
    endfunction

endpackage

@@ rtl/ses_if.sv @@
interface ses_corr_if;
    logic               valid;
    logic               ready;
    ses_pkg::ray_t      src_ray_x;
    ses_pkg::ray_t      src_ray_y;
    ses_pkg::ray_t      src_ray_z;
    ses_pkg::ray_t      dst_ray_x;
    ses_pkg::ray_t      dst_ray_y;
    ses_pkg::ray_t      dst_ray_z;

    modport source (
        output valid, src_ray_x, src_ray_y, src_ray_z, dst_ray_x, dst_ray_y, dst_ray_z,
        input  ready
    );
    modport sink (
        input  valid, src_ray_x, src_ray_y, src_ray_z, dst_ray_x, dst_ray_y, dst_ray_z,
        output ready
    );
endinterface

interface ses_score_if;
    logic                          valid;
    logic                          ready;
    logic [ses_pkg::DIST_W-1:0]    distance;
    logic                          is_inlier;
    logic                          degenerate;

    modport source (
        output valid, distance, is_inlier, degenerate,
        input  ready
    );
    modport sink (
        input  valid, distance, is_inlier, degenerate,
        output ready
    );
endinterface

@@ rtl/ses_regs.sv @@
module ses_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ses_pkg::APB_AW-1:0]   paddr,
    input  logic [ses_pkg::APB_DW-1:0]   pwdata,
    output logic [ses_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output ses_pkg::cfg_t                cfg
);

    localparam logic [2:0] REG_ROW0  = 3'd0;
    localparam logic [2:0] REG_ROW1  = 3'd1;
    localparam logic [2:0] REG_ROW2  = 3'd2;
    localparam logic [2:0] REG_FOCAL = 3'd3;
    localparam logic [2:0] REG_THR   = 3'd4;

    logic [ses_pkg::ROW_W-1:0] row0_reg;
    logic [ses_pkg::ROW_W-1:0] row1_reg;
    logic [ses_pkg::ROW_W-1:0] row2_reg;
    logic [ses_pkg::FOC_W-1:0] focal_reg;
    logic [ses_pkg::FOC_W-1:0] thr_reg;
    logic [2:0]                idx;
    logic                      wr;

    assign idx    = paddr[5:3];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg  <= '0;
            row1_reg  <= '0;
            row2_reg  <= '0;
            focal_reg <= ses_pkg::FOCAL_RESET;
            thr_reg   <= ses_pkg::THR_RESET;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_ROW0:  row0_reg  <= pwdata[ses_pkg::ROW_W-1:0];
                REG_ROW1:  row1_reg  <= pwdata[ses_pkg::ROW_W-1:0];
                REG_ROW2:  row2_reg  <= pwdata[ses_pkg::ROW_W-1:0];
                REG_FOCAL: focal_reg <= pwdata[ses_pkg::FOC_W-1:0];
                REG_THR:   thr_reg   <= pwdata[ses_pkg::FOC_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ROW0:  prdata = ses_pkg::APB_DW'(row0_reg);
            REG_ROW1:  prdata = ses_pkg::APB_DW'(row1_reg);
            REG_ROW2:  prdata = ses_pkg::APB_DW'(row2_reg);
            REG_FOCAL: prdata = ses_pkg::APB_DW'(focal_reg);
            REG_THR:   prdata = ses_pkg::APB_DW'(thr_reg);
            default:   prdata = '0;
        endcase
    end

    assign cfg.row0  = row0_reg;
    assign cfg.row1  = row1_reg;
    assign cfg.row2  = row2_reg;
    assign cfg.focal = focal_reg;
    assign cfg.thr   = thr_reg;

endmodule

@@ rtl/ses_front.sv @@
module ses_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  ses_pkg::corr_t              in_data,
    input  ses_pkg::cfg_t               cfg,
    output logic                        out_valid,
    output logic [ses_pkg::DEN_W-1:0]   out_dn,
    output ses_pkg::side_t              out_side
);

    localparam int EW = ses_pkg::E_W;

    logic [7:0] v_reg;

    logic signed [EW-1:0]               e [3][3];
    logic signed [ses_pkg::RAY_W-1:0]   f [3];
    logic signed [ses_pkg::RAY_W-1:0]   t [3];

    // stage 1: products
    logic signed [ses_pkg::PROD_W-1:0]  pa1_reg [3][3];
    logic signed [ses_pkg::PROD_W-1:0]  pb1_reg [2][3];
    logic signed [ses_pkg::RAY_W-1:0]   t1_reg  [3];
    // stage 2: lines
    logic signed [ses_pkg::LINE_W-1:0]  a2_reg  [3];
    logic signed [ses_pkg::LINE_W-1:0]  b2_reg  [2];
    logic signed [ses_pkg::RAY_W-1:0]   t2_reg  [3];
    // stage 3: rounded magnitudes, numerator partial products
    logic [ses_pkg::RND_W-1:0]          r3_reg  [4];
    logic signed [ses_pkg::PPL_W-1:0]   pl3_reg [3];
    logic signed [ses_pkg::PPH_W-1:0]   ph3_reg [3];
    // stage 4: squares, numerator
    logic [ses_pkg::SQ_W-1:0]           sq4_reg [4];
    logic signed [ses_pkg::NUM_W-1:0]   num4_reg;
    // stage 5: denominator, |N|
    logic [ses_pkg::DEN_W-1:0]          den5_reg;
    logic [ses_pkg::NMAG_W-1:0]         nmag5_reg;
    // stage 6
    logic [ses_pkg::DEN_W-1:0]          dn6_reg;
    logic [ses_pkg::S_W-1:0]            s6_reg;
    logic                               degen6_reg;
    logic [ses_pkg::FPL_W-1:0]          fl6_reg;
    logic [ses_pkg::FPH_W-1:0]          fh6_reg;
    // stage 7
    logic [ses_pkg::DEN_W-1:0]          dn7_reg;
    logic [ses_pkg::S_W-1:0]            s7_reg;
    logic                               degen7_reg;
    logic [ses_pkg::FP_W-1:0]           prod7_reg;
    // stage 8
    logic [ses_pkg::DEN_W-1:0]          dn8_reg;
    ses_pkg::side_t                     side8_reg;

    assign f[0] = in_data.src_x;
    assign f[1] = in_data.src_y;
    assign f[2] = in_data.src_z;
    assign t[0] = in_data.dst_x;
    assign t[1] = in_data.dst_y;
    assign t[2] = in_data.dst_z;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            e[0][j] = $signed(cfg.row0[EW*j +: EW]);
            e[1][j] = $signed(cfg.row1[EW*j +: EW]);
            e[2][j] = $signed(cfg.row2[EW*j +: EW]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[6:0], in_valid};
    end

    // stage 1..4
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t1_reg[i] <= t[i];
                t2_reg[i] <= t1_reg[i];
                for (int j = 0; j < 3; j++)
                    pa1_reg[i][j] <= e[i][j] * f[j];
            end
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 3; j++)
                    pb1_reg[i][j] <= e[j][i] * t[j];

            for (int i = 0; i < 3; i++)
                a2_reg[i] <= ses_pkg::LINE_W'(pa1_reg[i][0]) + ses_pkg::LINE_W'(pa1_reg[i][1])
                           + ses_pkg::LINE_W'(pa1_reg[i][2]);
            for (int i = 0; i < 2; i++)
                b2_reg[i] <= ses_pkg::LINE_W'(pb1_reg[i][0]) + ses_pkg::LINE_W'(pb1_reg[i][1])
                           + ses_pkg::LINE_W'(pb1_reg[i][2]);

            r3_reg[0] <= ses_pkg::round_mag(a2_reg[0]);
            r3_reg[1] <= ses_pkg::round_mag(a2_reg[1]);
            r3_reg[2] <= ses_pkg::round_mag(b2_reg[0]);
            r3_reg[3] <= ses_pkg::round_mag(b2_reg[1]);
            // a split into signed high half and unsigned low half
            for (int i = 0; i < 3; i++)
            begin
                pl3_reg[i] <= t2_reg[i] * $signed({1'b0, a2_reg[i][ses_pkg::HALF_W-1:0]});
                ph3_reg[i] <= t2_reg[i] *
                              $signed(a2_reg[i][ses_pkg::LINE_W-1:ses_pkg::HALF_W]);
            end

            for (int i = 0; i < 4; i++)
                sq4_reg[i] <= r3_reg[i] * r3_reg[i];
        end
    end

    logic signed [63:0] hsum;
    logic signed [63:0] lsum;
    logic signed [63:0] nsum;
    logic [ses_pkg::NUM_W-1:0] nabs;

    always_comb
    begin
        hsum = 64'(ph3_reg[0]) + 64'(ph3_reg[1]) + 64'(ph3_reg[2]);
        lsum = 64'(pl3_reg[0]) + 64'(pl3_reg[1]) + 64'(pl3_reg[2]);
        nsum = (hsum <<< ses_pkg::HALF_W) + lsum;
        nabs = num4_reg[ses_pkg::NUM_W-1] ? ses_pkg::NUM_W'(-num4_reg)
                                          : ses_pkg::NUM_W'(num4_reg);
    end

    // normalize D by even shifts into [2^60, 2^62)
    logic [ses_pkg::DEN_W-1:0] dna;
    logic [ses_pkg::S_W-1:0]   sa;
    logic [ses_pkg::DEN_W-1:0] dnb;
    logic [ses_pkg::S_W-1:0]   sb;

    always_comb
    begin
        dna = den5_reg;
        sa  = '0;
        if (dna[ses_pkg::DEN_W-1 -: 32] == '0)
        begin
            dna = dna << 32;
            sa  = sa + ses_pkg::S_W'(16);
        end
        if (dna[ses_pkg::DEN_W-1 -: 16] == '0)
        begin
            dna = dna << 16;
            sa  = sa + ses_pkg::S_W'(8);
        end
    end

    always_comb
    begin
        dnb = dn6_reg;
        sb  = s6_reg;
        if (dnb[ses_pkg::DEN_W-1 -: 8] == '0)
        begin
            dnb = dnb << 8;
            sb  = sb + ses_pkg::S_W'(4);
        end
        if (dnb[ses_pkg::DEN_W-1 -: 4] == '0)
        begin
            dnb = dnb << 4;
            sb  = sb + ses_pkg::S_W'(2);
        end
        if (dnb[ses_pkg::DEN_W-1 -: 2] == '0)
        begin
            dnb = dnb << 2;
            sb  = sb + ses_pkg::S_W'(1);
        end
    end

    logic [ses_pkg::SH_W-1:0] sh;
    assign sh = ses_pkg::SH_W'(prod7_reg) << s7_reg;

    // stage 4..8
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num4_reg  <= nsum[ses_pkg::NUM_W-1:0];

            den5_reg  <= ses_pkg::DEN_W'(sq4_reg[0]) + ses_pkg::DEN_W'(sq4_reg[1])
                       + ses_pkg::DEN_W'(sq4_reg[2]) + ses_pkg::DEN_W'(sq4_reg[3]);
            nmag5_reg <= nabs[ses_pkg::NMAG_W-1:0];

            dn6_reg    <= dna;
            s6_reg     <= sa;
            degen6_reg <= (den5_reg < ses_pkg::DEN_FLOOR);
            fl6_reg    <= nmag5_reg[31:0] * cfg.focal;
            fh6_reg    <= nmag5_reg[ses_pkg::NMAG_W-1:32] * cfg.focal;

            dn7_reg    <= dnb;
            s7_reg     <= sb;
            degen7_reg <= degen6_reg;
            prod7_reg  <= (ses_pkg::FP_W'(fh6_reg) << 32) + ses_pkg::FP_W'(fl6_reg);

            // low 24 bits never reach the quotient: divisor is q*2^24
            dn8_reg         <= dn7_reg;
            side8_reg.numer <= sh[24 +: ses_pkg::NUMER_W];
            side8_reg.degen <= degen7_reg;
        end
    end

    assign out_valid = v_reg[7];
    assign out_dn    = dn8_reg;
    assign out_side  = side8_reg;

endmodule

@@ rtl/ses_sqrt.sv @@
module ses_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ses_pkg::DEN_W-1:0]   in_dn,
    input  ses_pkg::side_t              in_side,
    output logic                        out_valid,
    output logic [ses_pkg::Q_W-1:0]     out_q,
    output ses_pkg::side_t              out_side
);

    localparam int N  = ses_pkg::Q_W;
    localparam int DW = ses_pkg::DEN_W;

    // one result bit per stage; the last stage keeps no remainder
    logic [N-1:0]   v_reg;
    logic [DW-1:0]  d_reg    [N-1];
    logic [DW-1:0]  r_reg    [N];
    ses_pkg::side_t side_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[N-2:0], in_valid};
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        localparam logic [DW-1:0] BIT = DW'(1) << (DW - 2 - 2 * k);

        logic [DW-1:0]  d_in;
        logic [DW-1:0]  r_in;
        logic [DW-1:0]  trial;
        logic [DW-1:0]  d_next;
        logic [DW-1:0]  r_next;
        ses_pkg::side_t s_in;

        if (k == 0)
        begin : g_first
            assign d_in = in_dn;
            assign r_in = '0;
            assign s_in = in_side;
        end
        else
        begin : g_rest
            assign d_in = d_reg[k-1];
            assign r_in = r_reg[k-1];
            assign s_in = side_reg[k-1];
        end

        always_comb
        begin
            trial = r_in + BIT;
            if (d_in >= trial)
            begin
                d_next = d_in - trial;
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                d_next = d_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]    <= r_next;
                side_reg[k] <= s_in;
            end
        end

        if (k < N - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                    d_reg[k] <= d_next;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_q     = r_reg[N-1][N-1:0];
    assign out_side  = side_reg[N-1];

endmodule

@@ rtl/ses_div.sv @@
module ses_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ses_pkg::Q_W-1:0]     in_q,
    input  ses_pkg::side_t              in_side,
    input  logic [ses_pkg::FOC_W-1:0]   thr,
    output logic                        out_valid,
    output logic [ses_pkg::DIST_W-1:0]  out_dist,
    output logic                        out_inlier,
    output logic                        out_degen
);

    localparam int N  = ses_pkg::DIST_W;
    localparam int RW = ses_pkg::REM_W;
    localparam int QW = ses_pkg::Q_W;

    // entry stage 0, then one quotient bit per stage 1..N
    logic [N:0]     v_reg;
    logic [N:0]     sat_reg;
    logic [N:0]     degen_reg;
    logic [RW-1:0]  rem_reg  [N];
    logic [QW-1:0]  q_reg    [N];
    logic [N-1:0]   quot_reg [N];

    logic           valid_out_reg;
    logic [N-1:0]   dist_reg;
    logic           inlier_reg;
    logic           degen_out_reg;

    logic           sat0;

    assign sat0 = (in_side.numer[ses_pkg::NUMER_W-1:RW] != '0)
               || (in_side.numer[RW-1:0] >= {in_q, {N{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            valid_out_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[N-1:0], in_valid};
            valid_out_reg <= v_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0]   <= sat0;
            degen_reg[0] <= in_side.degen;
            rem_reg[0]   <= in_side.numer[RW-1:0];
            q_reg[0]     <= in_q;
        end
    end

    for (genvar j = 1; j <= N; j++)
    begin : g_step
        localparam int B = N - j;

        logic [RW-1:0] dv;
        logic [RW-1:0] rem_next;
        logic [N-1:0]  quot_in;
        logic [N-1:0]  quot_next;

        if (j == 1)
        begin : g_first
            assign quot_in = '0;
        end
        else
        begin : g_rest
            assign quot_in = quot_reg[j-2];
        end

        always_comb
        begin
            dv        = RW'(q_reg[j-1]) << B;
            rem_next  = rem_reg[j-1];
            quot_next = quot_in;
            if (rem_reg[j-1] >= dv)
            begin
                rem_next     = rem_reg[j-1] - dv;
                quot_next[B] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sat_reg[j]    <= sat_reg[j-1];
                degen_reg[j]  <= degen_reg[j-1];
                quot_reg[j-1] <= quot_next;
            end
        end

        if (j < N)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= rem_next;
                    q_reg[j]   <= q_reg[j-1];
                end
            end
        end
    end

    logic [N-1:0] dist_next;
    assign dist_next = (sat_reg[N] || degen_reg[N]) ? ses_pkg::DIST_MAX : quot_reg[N-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg      <= dist_next;
            inlier_reg    <= !degen_reg[N] && (dist_next < thr);
            degen_out_reg <= degen_reg[N];
        end
    end

    assign out_valid  = valid_out_reg;
    assign out_dist   = dist_reg;
    assign out_inlier = inlier_reg;
    assign out_degen  = degen_out_reg;

endmodule

@@ rtl/sampson_epipolar_scorer.sv @@
// Sampson epipolar distance scorer.
// corr (sink): one correspondence per transaction, source and destination rays
//   in signed Q3.16. score (source): distance in Q12.4 pixels with inlier and
//   degenerate flags, one transaction per correspondence, in order.
// APB port: 64-bit registers at 8*i: essential rows 0..2, focal length,
//   inlier threshold. Write only while no correspondence is in flight.
// Throughput: one correspondence per cycle while score is not stalled; the
//   8-stage line/denominator front end, the 31-stage square root (one root
//   bit per stage) and the 18-stage restoring divider (entry stage, one
//   quotient bit per stage, output stage) are all fully pipelined.
// Stall: when score is valid and not taken, the whole pipeline holds and
//   corr.ready drops in the same cycle; nothing is dropped or repeated.
// Reset: pipeline emptied, matrix cleared, focal 1000.0, threshold 2.0.
module sampson_epipolar_scorer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ses_pkg::APB_AW-1:0]  paddr,
    input  logic [ses_pkg::APB_DW-1:0]  pwdata,
    output logic [ses_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    ses_corr_if.sink                    corr,
    ses_score_if.source                 score
);

    ses_pkg::cfg_t                  cfg;
    ses_pkg::corr_t                 corr_data;
    logic                           en;

    logic                           fr_valid;
    logic [ses_pkg::DEN_W-1:0]      fr_dn;
    ses_pkg::side_t                 fr_side;

    logic                           sq_valid;
    logic [ses_pkg::Q_W-1:0]        sq_q;
    ses_pkg::side_t                 sq_side;

    assign en         = !score.valid || score.ready;
    assign corr.ready = en;

    assign corr_data.src_x = corr.src_ray_x;
    assign corr_data.src_y = corr.src_ray_y;
    assign corr_data.src_z = corr.src_ray_z;
    assign corr_data.dst_x = corr.dst_ray_x;
    assign corr_data.dst_y = corr.dst_ray_y;
    assign corr_data.dst_z = corr.dst_ray_z;

    ses_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ses_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (corr.valid),
        .in_data   (corr_data),
        .cfg       (cfg),
        .out_valid (fr_valid),
        .out_dn    (fr_dn),
        .out_side  (fr_side)
    );

    ses_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_dn     (fr_dn),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_q     (sq_q),
        .out_side  (sq_side)
    );

    ses_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (sq_valid),
        .in_q       (sq_q),
        .in_side    (sq_side),
        .thr        (cfg.thr),
        .out_valid  (score.valid),
        .out_dist   (score.distance),
        .out_inlier (score.is_inlier),
        .out_degen  (score.degenerate)
    );

endmodule
